// ===== src/eeprom_serial_request_framer_unit_macros.svh =====
// Assertion macros used by the EEPROM request framer state module
`ifndef EEPROM_SERIAL_REQUEST_FRAMER_UNIT_MACROS_SVH
`define EEPROM_SERIAL_REQUEST_FRAMER_UNIT_MACROS_SVH

// same-cycle implication on clk_i, disabled while rst_ni is low
`define ESF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, disabled while rst_ni is low
`define ESF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/esf_pkg.sv =====
// Package with types and constants of the EEPROM request framer
`timescale 1ns / 1ps

package esf_pkg;

  localparam int DATA_BITS  = 64;
  localparam int SKIP_BITS  = 4;
  localparam int ADDR_W     = 14;
  localparam int ADDR_SHORT = 6;
  localparam int ADDR_LONG  = 14;
  localparam int CMD_W      = 2;
  localparam int CNT_W      = 7;

  localparam int DATA_IDX_W = $clog2(DATA_BITS);
  localparam int ADDR_IDX_W = $clog2(ADDR_LONG);

  localparam int SEND_LEN_SHORT_READ  = 2 + ADDR_SHORT + 1;
  localparam int SEND_LEN_LONG_READ   = 2 + ADDR_LONG + 1;
  localparam int SEND_LEN_SHORT_WRITE = 2 + ADDR_SHORT + DATA_BITS + 1;
  localparam int SEND_LEN_LONG_WRITE  = 2 + ADDR_LONG + DATA_BITS + 1;
  localparam int RECV_LEN             = SKIP_BITS + DATA_BITS;

  localparam logic [CMD_W-1:0] CMD_SLOT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [ADDR_W-1:0]    address;
    logic [DATA_BITS-1:0] write_data;
    logic                 line_in;
  } in_word_t;

  typedef struct packed {
    logic                 line_out;
    logic                 drive;
    logic [DATA_BITS-1:0] read_data;
    logic                 read_done;
    logic                 write_done;
    logic                 busy_res;
  } out_word_t;

endpackage

// ===== src/esf_ifs.sv =====
// Valid/ready channel interfaces for request slots and slot results
`timescale 1ns / 1ps

interface esf_in_if;
  logic             valid;
  logic             ready;
  esf_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface esf_out_if;
  logic              valid;
  logic              ready;
  esf_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/esf_state.sv =====
// Request state registers and per-slot next-state and result logic
`timescale 1ns / 1ps
`include "eeprom_serial_request_framer_unit_macros.svh"

module esf_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               accept_i,
  input  esf_pkg::in_word_t  word_i,
  output esf_pkg::out_word_t res_o
);

  localparam int CW = esf_pkg::CNT_W;
  localparam int AW = esf_pkg::ADDR_W;
  localparam int DW = esf_pkg::DATA_BITS;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_SEND_SHORT = 3'd1;
  localparam logic [2:0] PH_SEND_LONG  = 3'd2;
  localparam logic [2:0] PH_RECV       = 3'd3;
  localparam logic [2:0] PH_POLL       = 3'd4;

  localparam logic [CW-1:0] CNT_ONE   = CW'(1);
  localparam logic [CW-1:0] CNT_TWO   = CW'(2);
  localparam logic [CW-1:0] A_SHORT   = CW'(esf_pkg::ADDR_SHORT);
  localparam logic [CW-1:0] A_LONG    = CW'(esf_pkg::ADDR_LONG);
  localparam logic [CW-1:0] D_BITS    = CW'(DW);
  localparam logic [CW-1:0] SKIP      = CW'(esf_pkg::SKIP_BITS);
  localparam logic [CW-1:0] RECV_LEN  = CW'(esf_pkg::RECV_LEN);
  localparam logic [CW-1:0] LEN_SR    = CW'(esf_pkg::SEND_LEN_SHORT_READ);
  localparam logic [CW-1:0] LEN_LR    = CW'(esf_pkg::SEND_LEN_LONG_READ);
  localparam logic [CW-1:0] LEN_SW    = CW'(esf_pkg::SEND_LEN_SHORT_WRITE);
  localparam logic [CW-1:0] LEN_LW    = CW'(esf_pkg::SEND_LEN_LONG_WRITE);
  localparam logic [AW-1:0] SHORT_MSK = AW'((1 << esf_pkg::ADDR_SHORT) - 1);

  logic          long_q;
  logic [2:0]    phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] shift_q, shift_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          write_q, write_d;

  logic [CW-1:0] count_inc;
  logic [CW-1:0] abits;
  logic [CW-1:0] send_len;
  logic [CW-1:0] addr_off;
  logic [CW-1:0] data_off;
  logic [CW-1:0] addr_idx;
  logic [CW-1:0] data_idx;
  logic          send_bit;
  logic          in_idle;
  logic          in_send;
  logic          is_start;
  logic          is_done;
  esf_pkg::out_word_t res;

  assign count_inc = count_q + CNT_ONE;
  assign abits     = (phase_q == PH_SEND_LONG) ? A_LONG : A_SHORT;
  assign addr_off  = count_q - CNT_TWO;
  assign data_off  = addr_off - abits;
  assign addr_idx  = abits - CNT_ONE - addr_off;
  assign data_idx  = D_BITS - CNT_ONE - data_off;

  always_comb begin
    unique case ({write_q, phase_q == PH_SEND_LONG})
      2'b00: send_len = LEN_SR;
      2'b01: send_len = LEN_LR;
      2'b10: send_len = LEN_SW;
      2'b11: send_len = LEN_LW;
      default: send_len = LEN_SR;
    endcase
  end

  always_comb begin
    priority if (count_q == '0) begin
      send_bit = 1'b1;
    end else if (count_q == CNT_ONE) begin
      send_bit = !write_q;
    end else if (addr_off < abits) begin
      send_bit = addr_q[addr_idx[esf_pkg::ADDR_IDX_W-1:0]];
    end else if (write_q && (data_off < D_BITS)) begin
      send_bit = shift_q[data_idx[esf_pkg::DATA_IDX_W-1:0]];
    end else begin
      send_bit = 1'b0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    shift_d = shift_q;
    addr_d  = addr_q;
    write_d = write_q;
    res     = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if ((word_i.command == esf_pkg::CMD_READ) ||
            (word_i.command == esf_pkg::CMD_WRITE)) begin
          write_d = (word_i.command == esf_pkg::CMD_WRITE);
          addr_d  = long_q ? word_i.address : (word_i.address & SHORT_MSK);
          shift_d = write_d ? word_i.write_data : '0;
          count_d = '0;
          phase_d = long_q ? PH_SEND_LONG : PH_SEND_SHORT;
        end
      end
      PH_SEND_SHORT, PH_SEND_LONG: begin
        res.line_out = send_bit;
        res.drive    = 1'b1;
        count_d      = count_inc;
        if (count_inc >= send_len) begin
          count_d = '0;
          if (write_q) begin
            phase_d = PH_POLL;
          end else begin
            shift_d = '0;
            phase_d = PH_RECV;
          end
        end
      end
      PH_RECV: begin
        if (count_q >= SKIP) begin
          shift_d = {shift_q[DW-2:0], word_i.line_in};
        end
        count_d = count_inc;
        if (count_inc >= RECV_LEN) begin
          res.read_data = shift_d;
          res.read_done = 1'b1;
          count_d       = '0;
          phase_d       = PH_IDLE;
        end
      end
      PH_POLL: begin
        if (word_i.line_in) begin
          res.write_done = 1'b1;
          phase_d        = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    res.busy_res = (phase_d != PH_IDLE);
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= 1'b0;
    end else if (cfg_we_i) begin
      long_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      shift_q <= '0;
      addr_q  <= '0;
      write_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
      write_q <= write_d;
    end
  end

  assign in_idle  = (phase_q == PH_IDLE);
  assign in_send  = (phase_q == PH_SEND_SHORT) || (phase_q == PH_SEND_LONG);
  assign is_start = (word_i.command == esf_pkg::CMD_READ) ||
                    (word_i.command == esf_pkg::CMD_WRITE);
  assign is_done  = res.read_done || res.write_done;

  `ESF_ASSERT_NXT(a_start_leaves_idle, accept_i && in_idle && is_start, !in_idle, "start kept idle")
  `ESF_ASSERT_IMP(a_drive_in_send, res.drive, in_send, "drive outside send phase")
  `ESF_ASSERT_IMP(a_count_bound, 1'b1, count_q < LEN_LW, "bit count out of range")
  `ESF_ASSERT_NXT(a_done_to_idle, accept_i && is_done, in_idle, "done without return to idle")

endmodule

// ===== src/esf_out_stage.sv =====
// Result register that decouples slot acceptance from result delivery
`timescale 1ns / 1ps

module esf_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  esf_pkg::out_word_t word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output esf_pkg::out_word_t word_o
);

  logic               valid_q;
  esf_pkg::out_word_t word_q;
  logic               load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;

endmodule

// ===== src/eeprom_serial_request_framer_unit.sv =====
// Top level of the bit-serial cartridge EEPROM request framer
//
//   channel   dir  handshake      word
//   in_i      in   valid/ready    command, address, write_data, line_in
//   out_o     out  valid/ready    line_out, drive, read_data, done flags, busy_res
//   cfg       in   cfg_we_i       cfg_wdata_i = long_address
//
// One word per cycle unless out_o stalls; each accepted slot word yields its result word in the cycle after.
// The result register sets the rate: a new word enters while it is empty or the held one is taken.
// A stalled out_o holds the result and blocks in_i until out_o.ready rises.
// Reset returns the request state to idle and selects the short address.
`timescale 1ns / 1ps

module eeprom_serial_request_framer_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  esf_in_if.sink          in_i,
  esf_out_if.source       out_o
);

  logic               accept;
  logic               in_ready;
  esf_pkg::out_word_t res;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  esf_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .word_i      (in_i.data),
    .res_o       (res)
  );

  esf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .word_i      (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .word_o      (out_o.data)
  );

endmodule

// ===== test/eeprom_serial_request_framer_unit_tb.sv =====
// Self-checking testbench for the EEPROM request framer: drives framed read/write requests
`timescale 1ns / 1ps

module eeprom_serial_request_framer_unit_tb;

  localparam logic [esf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 100000;
  localparam int QUIET_FROM  = 1500;
  localparam int QUIET_TO    = 2700;
  localparam int WORD_TARGET = 1850;

  typedef enum logic [2:0] {
    LINK_IDLE,
    LINK_SEND_SHORT,
    LINK_SEND_LONG,
    LINK_RECEIVE,
    LINK_POLL
  } link_phase_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  esf_in_if  in_if ();
  esf_out_if out_if ();

  eeprom_serial_request_framer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  link_phase_e                   link_ph;
  logic [esf_pkg::CNT_W-1:0]     bit_cnt;
  logic [esf_pkg::DATA_BITS-1:0] shift_reg;
  logic [esf_pkg::ADDR_W-1:0]    held_addr;
  logic                          wr_req;
  logic                          long_cfg;

  esf_pkg::in_word_t  slot_q[$];
  esf_pkg::out_word_t result_q[$];
  int        queued_cnt;
  int        taken_cnt;
  int        err_cnt;
  int        cycle_cnt;
  logic      in_took;
  logic      gen_long;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic esf_pkg::out_word_t frame_slot(esf_pkg::in_word_t w);
    esf_pkg::out_word_t r;
    int unsigned abits;
    int unsigned send_len;
    int unsigned idx;
    r = '0;
    case (link_ph)
      LINK_IDLE: begin
        if (w.command == esf_pkg::CMD_READ || w.command == esf_pkg::CMD_WRITE) begin
          wr_req    = (w.command == esf_pkg::CMD_WRITE);
          held_addr = long_cfg ? w.address : (w.address & 14'h3F);
          shift_reg = wr_req ? w.write_data : '0;
          bit_cnt   = '0;
          link_ph   = long_cfg ? LINK_SEND_LONG : LINK_SEND_SHORT;
        end
      end
      LINK_SEND_SHORT, LINK_SEND_LONG: begin
        abits    = (link_ph == LINK_SEND_LONG) ? esf_pkg::ADDR_LONG : esf_pkg::ADDR_SHORT;
        send_len = 3 + abits + (wr_req ? esf_pkg::DATA_BITS : 0);
        idx      = bit_cnt;
        r.drive  = 1'b1;
        if (idx == 0) begin
          r.line_out = 1'b1;
        end else if (idx == 1) begin
          r.line_out = !wr_req;
        end else if (idx - 2 < abits) begin
          r.line_out = held_addr[abits - 1 - (idx - 2)];
        end else if (wr_req && (idx - 2 - abits) < esf_pkg::DATA_BITS) begin
          r.line_out = shift_reg[esf_pkg::DATA_BITS - 1 - (idx - 2 - abits)];
        end
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt >= send_len) begin
          bit_cnt = '0;
          if (wr_req) begin
            link_ph = LINK_POLL;
          end else begin
            shift_reg = '0;
            link_ph   = LINK_RECEIVE;
          end
        end
      end
      LINK_RECEIVE: begin
        if (bit_cnt >= esf_pkg::SKIP_BITS) begin
          shift_reg = {shift_reg[esf_pkg::DATA_BITS-2:0], w.line_in};
        end
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt >= esf_pkg::RECV_LEN) begin
          r.read_data = shift_reg;
          r.read_done = 1'b1;
          bit_cnt     = '0;
          link_ph     = LINK_IDLE;
        end
      end
      LINK_POLL: begin
        if (w.line_in) begin
          r.write_done = 1'b1;
          link_ph      = LINK_IDLE;
        end
      end
      default: link_ph = LINK_IDLE;
    endcase
    r.busy_res = (link_ph != LINK_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
    end
  endfunction

  function automatic bit hold_off();
    return !(cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) && ($urandom_range(99) < 14);
  endfunction

  always @(posedge clk_i) begin
    esf_pkg::out_word_t exp;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, expected none actual %h", $time, out_if.data);
        end else begin
          exp = result_q.pop_front();
          check_field("line_out", exp.line_out, out_if.data.line_out);
          check_field("drive", exp.drive, out_if.data.drive);
          check_field("read_data", exp.read_data, out_if.data.read_data);
          check_field("read_done", exp.read_done, out_if.data.read_done);
          check_field("write_done", exp.write_done, out_if.data.write_done);
          check_field("busy_res", exp.busy_res, out_if.data.busy_res);
        end
      end
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(frame_slot(in_if.data));
        taken_cnt++;
      end
      if (cfg_we_i) long_cfg = cfg_wdata_i;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (slot_q.size() != 0 && !hold_off()) begin
        in_if.valid <= 1'b1;
        in_if.data  <= slot_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && !hold_off();
  end

  task automatic queue_word(logic [esf_pkg::CMD_W-1:0] cmd, logic [esf_pkg::ADDR_W-1:0] addr,
                            logic [esf_pkg::DATA_BITS-1:0] data, logic line);
    esf_pkg::in_word_t w;
    w.command    = cmd;
    w.address    = addr;
    w.write_data = data;
    w.line_in    = line;
    slot_q.push_back(w);
    queued_cnt++;
  endtask

  task automatic settle();
    while (taken_cnt != queued_cnt || result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    gen_long = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [esf_pkg::ADDR_W-1:0] pick_addr();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return esf_pkg::ADDR_W'($urandom);
    endcase
  endfunction

  function automatic logic [esf_pkg::DATA_BITS-1:0] pick_data();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {1'b1, 62'd0, 1'b1};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_noise();
    repeat ($urandom_range(3)) begin
      queue_word($urandom_range(1) ? CMD_UNUSED : esf_pkg::CMD_SLOT, pick_addr(), pick_data(),
                 1'($urandom_range(1)));
    end
  endtask

  task automatic queue_request(logic wr, int cut);
    int unsigned abits;
    int unsigned send_len;
    int unsigned body_len;
    logic [esf_pkg::CMD_W-1:0] cmd;
    logic line;
    abits    = gen_long ? esf_pkg::ADDR_LONG : esf_pkg::ADDR_SHORT;
    send_len = 3 + abits + (wr ? esf_pkg::DATA_BITS : 0);
    body_len = send_len + (wr ? ($urandom_range(9) == 0 ? $urandom_range(20, 40)
                                                       : $urandom_range(6)) + 1
                              : esf_pkg::RECV_LEN);
    queue_word(wr ? esf_pkg::CMD_WRITE : esf_pkg::CMD_READ, pick_addr(), pick_data(),
               1'($urandom_range(1)));
    for (int unsigned i = 0; i < body_len; i++) begin
      if (i == cut) write_cfg(!gen_long);
      cmd = ($urandom_range(9) == 0) ? esf_pkg::CMD_W'($urandom_range(1, 3)) : esf_pkg::CMD_SLOT;
      if (wr && i >= send_len) line = (i == body_len - 1);
      else line = 1'($urandom_range(1));
      queue_word(cmd, esf_pkg::ADDR_W'($urandom), {$urandom, $urandom}, line);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    link_ph      = LINK_IDLE;
    bit_cnt      = '0;
    shift_reg    = '0;
    held_addr    = '0;
    wr_req       = 1'b0;
    long_cfg     = 1'b0;
    gen_long     = 1'b0;
    queued_cnt   = 0;
    taken_cnt    = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    in_took      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    queue_word(esf_pkg::CMD_SLOT, '0, '0, 1'b0);
    queue_word(esf_pkg::CMD_SLOT, '1, '1, 1'b1);
    queue_word(CMD_UNUSED, '1, '1, 1'b1);
    queue_word(CMD_UNUSED, '0, '0, 1'b0);
    queue_request(1'b0, -1);
    queue_request(1'b1, -1);

    for (int p = 0; queued_cnt < WORD_TARGET; p++) begin
      write_cfg(1'((p < 2) ? (p == 1) : $urandom_range(1)));
      repeat ($urandom_range(3, 4)) begin
        if (queued_cnt < WORD_TARGET) begin
          queue_noise();
          queue_request(1'($urandom_range(1)),
                        ($urandom_range(3) == 0) ? $urandom_range(1, 70) : -1);
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== eeprom_serial_request_framer_unit.f =====
+incdir+src
src/esf_pkg.sv
src/esf_ifs.sv
src/esf_state.sv
src/esf_out_stage.sv
src/eeprom_serial_request_framer_unit.sv
test/eeprom_serial_request_framer_unit_tb.sv
